// ----- src/jtl_pkg.sv -----
// jtl_pkg: shared types, character constants and lexer mode codes for the
// JSON token lexer. No dependencies; imported by every module in src.
package jtl_pkg;

  // Text size limit; position counter saturates at the smaller of this - 1
  // and the 24-bit field maximum.
  localparam logic [63:0] MAX_TEXT_BYTES = 64'd16777216;
  localparam logic [63:0] FIELD_MAX      = 64'hFF_FFFF;
  localparam logic [63:0] POS_LIMIT_W    = (MAX_TEXT_BYTES - 64'd1 > FIELD_MAX) ?
                                           FIELD_MAX : (MAX_TEXT_BYTES - 64'd1);
  localparam logic [23:0] POS_LIMIT      = POS_LIMIT_W[23:0];
  localparam logic [23:0] CNT_MAX        = 24'hFF_FFFF;

  // Result queue depth (power of two)
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Lexer modes
  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_STR      = 4'd1;
  localparam logic [3:0] M_INT      = 4'd2;
  localparam logic [3:0] M_FRAC     = 4'd3;
  localparam logic [3:0] M_EXP      = 4'd4;
  localparam logic [3:0] M_EXPD     = 4'd5;
  localparam logic [3:0] M_WORD     = 4'd6;
  localparam logic [3:0] M_ERR_BASE = 4'd7;
  localparam logic [3:0] M_ERR_NL   = 4'd8;
  localparam logic [3:0] M_ERR_UNT  = 4'd9;
  localparam logic [3:0] M_ERR_UNX  = 4'd10;

  // Token kinds
  localparam logic [3:0] K_LBRACE   = 4'd0;
  localparam logic [3:0] K_RBRACE   = 4'd1;
  localparam logic [3:0] K_LBRACKET = 4'd2;
  localparam logic [3:0] K_RBRACKET = 4'd3;
  localparam logic [3:0] K_COLON    = 4'd4;
  localparam logic [3:0] K_COMMA    = 4'd5;
  localparam logic [3:0] K_STRING   = 4'd6;
  localparam logic [3:0] K_NUMBER   = 4'd7;
  localparam logic [3:0] K_BOOL     = 4'd8;
  localparam logic [3:0] K_END      = 4'd9;
  localparam logic [3:0] K_ERROR    = 4'd10;

  // Error codes
  localparam logic [1:0] E_NONE       = 2'd0;
  localparam logic [1:0] E_NEWLINE    = 2'd1;
  localparam logic [1:0] E_UNTERM     = 2'd2;
  localparam logic [1:0] E_UNEXPECTED = 2'd3;

  // Characters
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LOWER_E  = 8'h65;
  localparam logic [7:0] CH_UPPER_E  = 8'h45;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;

  // One result item
  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  error_code;
    logic [23:0] text_start;
    logic [23:0] text_length;
    logic [23:0] line_number;
    logic [23:0] column_number;
    logic        last_of_run;
  } result_t;

  // Results from one byte, pushed into the queue together
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- src/jtl_lexer.sv -----
// jtl_lexer: lexer state registers and the per-byte next-state / token logic.
// Depends on jtl_pkg. Produces up to two results per byte for the result queue.
module jtl_lexer
  import jtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] ch,
  input  logic       end_of_input,
  output push_t      push
);

  logic [3:0]  lexer_mode, lexer_mode_next;
  logic [23:0] byte_position, byte_position_next;
  logic [23:0] current_line, current_line_next;
  logic [23:0] current_column, current_column_next;
  logic [23:0] token_start, token_start_next;
  logic [23:0] token_line, token_line_next;
  logic [23:0] token_column, token_column_next;

  logic [23:0] pos_inc, line_inc, col_inc;
  logic        is_digit, is_alpha, pending, cont;
  logic [3:0]  cont_mode;
  result_t     ra, rb;
  logic        ra_v, rb_v;

  // Saturating counter steps
  assign pos_inc  = (byte_position < POS_LIMIT) ? byte_position + 24'd1 : byte_position;
  assign line_inc = (current_line < CNT_MAX) ? current_line + 24'd1 : current_line;
  assign col_inc  = (current_column < CNT_MAX) ? current_column + 24'd1 : current_column;

  assign is_digit = (ch inside {[8'h30:8'h39]});
  assign is_alpha = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  assign pending  = (lexer_mode inside {[M_INT:M_WORD]});

  // Can the byte extend a pending number or word
  always_comb begin
    cont      = 1'b0;
    cont_mode = lexer_mode;
    case (lexer_mode)
      M_INT: begin
        if (is_digit) begin
          cont = 1'b1;
        end else if (ch == CH_DOT) begin
          cont = 1'b1; cont_mode = M_FRAC;
        end else if (ch == CH_LOWER_E || ch == CH_UPPER_E) begin
          cont = 1'b1; cont_mode = M_EXP;
        end
      end
      M_FRAC: begin
        if (is_digit) begin
          cont = 1'b1;
        end else if (ch == CH_LOWER_E || ch == CH_UPPER_E) begin
          cont = 1'b1; cont_mode = M_EXP;
        end
      end
      M_EXP: begin
        if (is_digit || ch == CH_PLUS || ch == CH_MINUS) begin
          cont = 1'b1; cont_mode = M_EXPD;
        end
      end
      M_EXPD: cont = is_digit;
      M_WORD: cont = is_alpha;
      default: cont = 1'b0;
    endcase
    if (end_of_input) cont = 1'b0;
  end

  // Per-byte step
  always_comb begin
    lexer_mode_next     = lexer_mode;
    byte_position_next  = byte_position;
    current_line_next   = current_line;
    current_column_next = current_column;
    token_start_next    = token_start;
    token_line_next     = token_line;
    token_column_next   = token_column;
    ra   = '0;
    rb   = '0;
    ra_v = 1'b0;
    rb_v = 1'b0;

    if (lexer_mode inside {[M_ERR_NL:M_ERR_UNX]}) begin
      // sticky error: repeat stored code and location
      rb_v = 1'b1;
      rb.kind          = K_ERROR;
      rb.error_code    = 2'(lexer_mode - M_ERR_BASE);
      rb.text_start    = token_start;
      rb.line_number   = token_line;
      rb.column_number = token_column;
    end else if (lexer_mode == M_STR) begin
      if (end_of_input || ch == CH_LF) begin
        lexer_mode_next   = end_of_input ? M_ERR_UNT : M_ERR_NL;
        token_start_next  = byte_position;
        token_line_next   = current_line;
        token_column_next = current_column;
        rb_v = 1'b1;
        rb.kind          = K_ERROR;
        rb.error_code    = end_of_input ? E_UNTERM : E_NEWLINE;
        rb.text_start    = byte_position;
        rb.line_number   = current_line;
        rb.column_number = current_column;
      end else begin
        if (ch == CH_QUOTE) begin
          rb_v = 1'b1;
          rb.kind          = K_STRING;
          rb.text_start    = token_start;
          rb.text_length   = byte_position - token_start;
          rb.line_number   = token_line;
          rb.column_number = token_column;
          lexer_mode_next  = M_IDLE;
        end
        byte_position_next  = pos_inc;
        current_column_next = col_inc;
      end
    end else if (pending && cont) begin
      // number or word keeps going
      lexer_mode_next     = cont_mode;
      byte_position_next  = pos_inc;
      current_column_next = col_inc;
    end else begin
      // flush the pending token, then handle the byte from idle
      if (pending) begin
        ra_v = 1'b1;
        ra.kind          = (lexer_mode == M_WORD) ? K_BOOL : K_NUMBER;
        ra.text_start    = token_start;
        ra.text_length   = byte_position - token_start;
        ra.line_number   = token_line;
        ra.column_number = token_column;
      end
      lexer_mode_next  = M_IDLE;
      rb.text_start    = byte_position;
      rb.line_number   = current_line;
      rb.column_number = current_column;
      if (end_of_input) begin
        rb_v    = 1'b1;
        rb.kind = K_END;
      end else begin
        case (ch)
          CH_SPACE, CH_TAB, CH_CR: begin
            byte_position_next  = pos_inc;
            current_column_next = col_inc;
          end
          CH_LF: begin
            byte_position_next  = pos_inc;
            current_line_next   = line_inc;
            current_column_next = 24'd1;
          end
          CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COLON, CH_COMMA: begin
            rb_v = 1'b1;
            rb.text_length = 24'd1;
            case (ch)
              CH_LBRACE:   rb.kind = K_LBRACE;
              CH_RBRACE:   rb.kind = K_RBRACE;
              CH_LBRACKET: rb.kind = K_LBRACKET;
              CH_RBRACKET: rb.kind = K_RBRACKET;
              CH_COLON:    rb.kind = K_COLON;
              default:     rb.kind = K_COMMA;
            endcase
            byte_position_next  = pos_inc;
            current_column_next = col_inc;
          end
          CH_QUOTE: begin
            token_line_next     = current_line;
            token_column_next   = current_column;
            token_start_next    = pos_inc;
            byte_position_next  = pos_inc;
            current_column_next = col_inc;
            lexer_mode_next     = M_STR;
          end
          default: begin
            if (is_digit || ch == CH_MINUS || is_alpha) begin
              token_start_next    = byte_position;
              token_line_next     = current_line;
              token_column_next   = current_column;
              byte_position_next  = pos_inc;
              current_column_next = col_inc;
              lexer_mode_next     = is_alpha ? M_WORD : M_INT;
            end else begin
              // unexpected byte: sticky error at current location
              lexer_mode_next   = M_ERR_UNX;
              token_start_next  = byte_position;
              token_line_next   = current_line;
              token_column_next = current_column;
              rb_v = 1'b1;
              rb.kind       = K_ERROR;
              rb.error_code = E_UNEXPECTED;
            end
          end
        endcase
      end
    end

    // pack results, flag the final one
    ra.last_of_run = ~rb_v;
    rb.last_of_run = 1'b1;
    push = '0;
    if (in_valid) begin
      if (ra_v) begin
        push.r0    = ra;
        push.r1    = rb;
        push.count = rb_v ? 2'd2 : 2'd1;
      end else begin
        push.r0    = rb;
        push.r1    = rb;
        push.count = rb_v ? 2'd1 : 2'd0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lexer_mode     <= M_IDLE;
      byte_position  <= '0;
      current_line   <= 24'd1;
      current_column <= 24'd1;
      token_start    <= '0;
      token_line     <= 24'd1;
      token_column   <= 24'd1;
    end else if (in_valid) begin
      lexer_mode     <= lexer_mode_next;
      byte_position  <= byte_position_next;
      current_line   <= current_line_next;
      current_column <= current_column_next;
      token_start    <= token_start_next;
      token_line     <= token_line_next;
      token_column   <= token_column_next;
    end
  end

endmodule

// ----- src/jtl_result_fifo.sv -----
// jtl_result_fifo: result queue taking up to two results per cycle and
// presenting one beat per cycle while popped. Depends on jtl_pkg (result_t, push_t, QDEPTH).
module jtl_result_fifo
  import jtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  input  logic        pop,
  output logic        out_valid,
  output result_t     out_data,
  output logic [QAW:0] count
);

  result_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW-1:0] wr_ptr1;

  assign wr_ptr1   = wr_ptr + QAW'(1);
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.count == 2'd2) mem[wr_ptr1] <= push.r1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.count);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      count <= count + (QAW+1)'(push.count) - (QAW+1)'(pop);
    end
  end

endmodule

// ----- src/json_token_lexer.sv -----
// json_token_lexer: streaming JSON tokenizer, one text byte per beat.
// An input beat passes the input register, then the lexer step into the
// result queue, before its first result beat. One byte per cycle while
// s_tready is high; a byte that gives two tokens takes two output beats,
// set by the single output port. Synchronous active-high reset returns to
// idle, position 0, line 1, column 1, and empties the result queue.
module json_token_lexer
  import jtl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] ch
  input  logic         s_tlast,   // end_of_input
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [1:0] error_code, [25:2] text_start,
                                  // [49:26] text_length, [73:50] line_number,
                                  // [97:74] column_number, rest zero
  output logic [3:0]   m_tuser,   // [3:0] kind
  output logic         m_tlast    // last_of_run
);

  logic         in_valid;
  logic [7:0]   in_ch;
  logic         in_eoi;
  push_t        push;
  logic         pop;
  result_t      head;
  logic [QAW:0] count;
  logic [QAW:0] reserved;

  // Accept only while the queue has room for the byte in flight plus this one
  assign reserved = count + (in_valid ? (QAW+1)'(2) : (QAW+1)'(0));
  assign s_tready = (reserved <= (QAW+1)'(QDEPTH - 2));

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch  <= s_tdata;
      in_eoi <= s_tlast;
    end
  end

  jtl_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .ch           (in_ch),
    .end_of_input (in_eoi),
    .push         (push)
  );

  assign pop = m_tvalid && m_tready;

  jtl_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_data  (head),
    .count     (count)
  );

  // Output beat packing
  assign m_tdata = {6'd0, head.column_number, head.line_number, head.text_length,
                    head.text_start, head.error_code};
  assign m_tuser = head.kind;
  assign m_tlast = head.last_of_run;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for json_token_lexer: directed JSON text, random token
// streams with random handshake gaps, and one sticky error at the end.
// Depends on jtl_pkg and json_token_lexer from src.
`timescale 1ns / 100ps

module testbench;
  import jtl_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_ITEMS   = 1400;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = 8'h00;   // [7:0] ch
  logic         s_tlast  = 1'b0;    // end_of_input
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;            // [1:0] error_code, [25:2] text_start,
                                    // [49:26] text_length, [73:50] line_number,
                                    // [97:74] column_number
  logic [3:0]   m_tuser;            // [3:0] kind
  logic         m_tlast;            // last_of_run

  json_token_lexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lexer state mirror
  logic [3:0]  scan_mode;
  logic [23:0] at_pos, at_line, at_col;
  logic [23:0] tok_pos, tok_line, tok_col;
  result_t     made [2];
  int          made_n;
  result_t     expected_tokens [$];

  int  mismatches = 0;
  int  items_sent = 0;
  bit  calm       = 1'b0;   // no gaps or stalls on either side while set
  int  sink_wait  = 0;
  int  quiet      = 0;
  result_t want;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [23:0] bump(input logic [23:0] v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 24'd1;
  endfunction

  task automatic reset_model();
    scan_mode = M_IDLE;
    at_pos    = 24'd0;
    at_line   = 24'd1;
    at_col    = 24'd1;
    tok_pos   = 24'd0;
    tok_line  = 24'd1;
    tok_col   = 24'd1;
  endtask

  task automatic count_byte();
    if (at_pos < POS_LIMIT) at_pos = at_pos + 24'd1;
  endtask

  task automatic move_on();
    count_byte();
    at_col = bump(at_col);
  endtask

  task automatic mark_here();
    tok_pos  = at_pos;
    tok_line = at_line;
    tok_col  = at_col;
  endtask

  task automatic add_result(input logic [3:0] k, input logic [1:0] code,
                            input logic [23:0] start, input logic [23:0] len,
                            input logic [23:0] ln, input logic [23:0] cl);
    made[made_n] = {k, code, start, len, ln, cl, 1'b0};
    made_n++;
  endtask

  task automatic enter_fault(input logic [1:0] code);
    scan_mode = M_ERR_BASE + {2'b00, code};
    mark_here();
  endtask

  task automatic add_fault();
    logic [3:0] d;
    d = scan_mode - M_ERR_BASE;
    add_result(K_ERROR, d[1:0], tok_pos, 24'd0, tok_line, tok_col);
  endtask

  // True if c extends the pending number or word; may move to the next number part
  function automatic logic grows_token(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    case (scan_mode)
      M_INT: begin
        if (is_digit(c)) ok = 1'b1;
        else if (c == CH_DOT) begin
          scan_mode = M_FRAC;
          ok = 1'b1;
        end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
          scan_mode = M_EXP;
          ok = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(c)) ok = 1'b1;
        else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
          scan_mode = M_EXP;
          ok = 1'b1;
        end
      end
      M_EXP: begin
        if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
          scan_mode = M_EXPD;
          ok = 1'b1;
        end
      end
      M_EXPD: ok = is_digit(c);
      default: ok = is_letter(c);
    endcase
    return ok;
  endfunction

  // A byte seen with no token pending
  task automatic lex_idle(input logic [7:0] c);
    logic [3:0] k;
    logic       punct;
    punct = 1'b1;
    k = K_LBRACE;
    case (c)
      CH_SPACE, CH_TAB, CH_CR: begin
        punct = 1'b0;
        move_on();
      end
      CH_LF: begin
        punct = 1'b0;
        count_byte();
        at_line = bump(at_line);
        at_col  = 24'd1;
      end
      CH_LBRACE:   k = K_LBRACE;
      CH_RBRACE:   k = K_RBRACE;
      CH_LBRACKET: k = K_LBRACKET;
      CH_RBRACKET: k = K_RBRACKET;
      CH_COLON:    k = K_COLON;
      CH_COMMA:    k = K_COMMA;
      CH_QUOTE: begin
        punct = 1'b0;
        tok_line = at_line;
        tok_col  = at_col;
        move_on();
        tok_pos   = at_pos;
        scan_mode = M_STR;
      end
      default: begin
        punct = 1'b0;
        if (is_digit(c) || c == CH_MINUS) begin
          mark_here();
          move_on();
          scan_mode = M_INT;
        end else if (is_letter(c)) begin
          mark_here();
          move_on();
          scan_mode = M_WORD;
        end else begin
          enter_fault(E_UNEXPECTED);
          add_fault();
        end
      end
    endcase
    if (punct) begin
      add_result(k, E_NONE, at_pos, 24'd1, at_line, at_col);
      move_on();
    end
  endtask

  // Expected tokens for one accepted input beat
  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    logic held;
    held   = 1'b0;
    made_n = 0;
    if (scan_mode >= M_ERR_NL && scan_mode <= M_ERR_UNX) begin
      add_fault();
    end else if (scan_mode == M_STR) begin
      if (eoi) begin
        enter_fault(E_UNTERM);
        add_fault();
      end else if (c == CH_QUOTE) begin
        add_result(K_STRING, E_NONE, tok_pos, at_pos - tok_pos, tok_line, tok_col);
        move_on();
        scan_mode = M_IDLE;
      end else if (c == CH_LF) begin
        enter_fault(E_NEWLINE);
        add_fault();
      end else begin
        move_on();
      end
    end else begin
      if (scan_mode >= M_INT && scan_mode <= M_WORD) begin
        if (!eoi && grows_token(c)) begin
          move_on();
          held = 1'b1;
        end else begin
          add_result(scan_mode == M_WORD ? K_BOOL : K_NUMBER, E_NONE, tok_pos,
                     at_pos - tok_pos, tok_line, tok_col);
        end
      end
      if (!held) begin
        scan_mode = M_IDLE;
        if (eoi) add_result(K_END, E_NONE, at_pos, 24'd0, at_line, at_col);
        else lex_idle(c);
      end
    end
    if (made_n > 0) made[made_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < made_n; i++)
      expected_tokens.insert(expected_tokens.size(), made[i]);
  endtask

  // One input beat, after a random gap; tvalid stays high when no gap follows
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lex_byte(c, eoi);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] digit_ch();
    int r;
    r = $urandom_range(0, 9);
    return "0" + r[7:0];
  endfunction

  function automatic logic [7:0] letter_ch();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? "A" + r[7:0] : "a" + r[7:0] - 8'd26;
  endfunction

  function automatic logic [7:0] string_ch();
    int r;
    logic [7:0] c;
    do begin
      r = $urandom_range(0, 255);
      c = r[7:0];
    end while (c == CH_QUOTE || c == CH_LF);
    return c;
  endfunction

  task automatic log_mismatch(input string what, input logic [23:0] got,
                              input logic [23:0] exp_val);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // Result sink with random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else if (m_tvalid && m_tready) begin
      sink_wait = calm ? 0 : $urandom_range(0, 17);
      m_tready <= (sink_wait == 0);
    end else if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
      m_tready <= (sink_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare every result beat with the oldest expected token
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tokens.size() == 0) begin
        log_mismatch("unexpected result beat, kind", {20'd0, m_tuser}, 24'd0);
      end else begin
        want = expected_tokens.pop_front();
        if (m_tuser !== want.kind)
          log_mismatch("kind", {20'd0, m_tuser}, {20'd0, want.kind});
        if (m_tdata[1:0] !== want.error_code)
          log_mismatch("error_code", {22'd0, m_tdata[1:0]}, {22'd0, want.error_code});
        if (m_tdata[25:2] !== want.text_start)
          log_mismatch("text_start", m_tdata[25:2], want.text_start);
        if (m_tdata[49:26] !== want.text_length)
          log_mismatch("text_length", m_tdata[49:26], want.text_length);
        if (m_tdata[73:50] !== want.line_number)
          log_mismatch("line_number", m_tdata[73:50], want.line_number);
        if (m_tdata[97:74] !== want.column_number)
          log_mismatch("column_number", m_tdata[97:74], want.column_number);
        if (m_tlast !== want.last_of_run)
          log_mismatch("last_of_run", {23'd0, m_tlast}, {23'd0, want.last_of_run});
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Object open, string with a high byte, colon, array open
  task automatic test_punctuation_and_strings();
    send_text("{\"");
    send_item(8'hFF, 1'b0);
    send_text("\":[");
  endtask

  // Signed number with fraction and exponent, ended by a comma
  task automatic test_numbers();
    send_text("-1.5E+9,");
  endtask

  // Word ended by a closing bracket, then the closing brace
  task automatic test_words();
    send_text("x]}");
  endtask

  task automatic test_whitespace();
    calm = 1'b1;
    send_item(CH_TAB, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_SPACE, 1'b0);
    calm = 1'b0;
  endtask

  // Number ended by a letter, end flushing a word, end with nothing pending
  task automatic test_end_of_input();
    send_text("2a");
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  // Random token streams; tokens often abut, so one byte may close one and open another
  task automatic test_random_text();
    int  pick, n;
    bit  neg;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 59) == 0) calm = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        case ($urandom_range(0, 5))
          0: send_item(CH_LBRACE, 1'b0);
          1: send_item(CH_RBRACE, 1'b0);
          2: send_item(CH_LBRACKET, 1'b0);
          3: send_item(CH_RBRACKET, 1'b0);
          4: send_item(CH_COLON, 1'b0);
          default: send_item(CH_COMMA, 1'b0);
        endcase
      end else if (pick < 36) begin
        case ($urandom_range(0, 3))
          0: send_item(CH_SPACE, 1'b0);
          1: send_item(CH_TAB, 1'b0);
          2: send_item(CH_CR, 1'b0);
          default: send_item(CH_LF, 1'b0);
        endcase
      end else if (pick < 55) begin
        send_item(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 8)) send_item(string_ch(), 1'b0);
        send_item(CH_QUOTE, 1'b0);
      end else if (pick < 77) begin
        // a lone '-' is a number too, but a leading '.' is not
        neg = ($urandom_range(0, 2) == 0);
        if (neg) send_item(CH_MINUS, 1'b0);
        n = $urandom_range(neg ? 0 : 1, 4);
        repeat (n) send_item(digit_ch(), 1'b0);
        if ($urandom_range(0, 1)) begin
          send_item(CH_DOT, 1'b0);
          repeat ($urandom_range(0, 3)) send_item(digit_ch(), 1'b0);
        end
        if ($urandom_range(0, 1)) begin
          send_item($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E, 1'b0);
          case ($urandom_range(0, 2))
            0: send_item(CH_PLUS, 1'b0);
            1: send_item(CH_MINUS, 1'b0);
            default: ;
          endcase
          repeat ($urandom_range(0, 3)) send_item(digit_ch(), 1'b0);
        end
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) send_item(letter_ch(), 1'b0);
      end else begin
        send_item(string_ch(), 1'b1);
      end
    end
    calm = 1'b0;
  endtask

  // One randomly chosen error, then more beats that must repeat it
  task automatic test_sticky_error();
    int         r;
    logic [1:0] fault;
    logic [7:0] c;
    r = $urandom_range(1, 3);
    fault = r[1:0];
    send_item(CH_COMMA, 1'b0);
    if (fault == E_UNEXPECTED) begin
      do begin
        r = $urandom_range(0, 255);
        c = r[7:0];
      end while (is_digit(c) || is_letter(c) || c == CH_MINUS || c == CH_QUOTE ||
                 c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
                 c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACKET ||
                 c == CH_RBRACKET || c == CH_COLON || c == CH_COMMA);
      send_item(c, 1'b0);
    end else begin
      send_item(CH_QUOTE, 1'b0);
      send_item(string_ch(), 1'b0);
      if (fault == E_NEWLINE) send_item(CH_LF, 1'b0);
      else send_item(string_ch(), 1'b1);
    end
    repeat (6) begin
      r = $urandom_range(0, 255);
      send_item(r[7:0], 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_punctuation_and_strings();
    test_numbers();
    test_words();
    test_whitespace();
    test_end_of_input();
    test_random_text();
    test_sticky_error();
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
